/* hw/rtl/tgc_pkg.sv */
// Shared types, constants and helpers for the touch gesture classifier.
// No dependencies; every other file in hw/rtl uses it by scoped name.
`timescale 1ns / 1ps

package tgc_pkg;

  // Display size in pixels; coordinates at or beyond it are clamped
  localparam int unsigned SCREEN_WIDTH  = 360;
  localparam int unsigned SCREEN_HEIGHT = 360;

  localparam int unsigned COORD_W = 12;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned DELTA_W = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Clamp limits, one bit wider than a coordinate so 4096 still fits
  localparam logic [COORD_W:0] SCREEN_W_LIM = (COORD_W+1)'(SCREEN_WIDTH);
  localparam logic [COORD_W:0] SCREEN_H_LIM = (COORD_W+1)'(SCREEN_HEIGHT);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SWIPE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIFT_LIM  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO_NUM  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO_DEN  = 3'd6;

  typedef enum logic [2:0] {
    GEST_NONE     = 3'd0,
    GEST_ACTIVITY = 3'd1,
    GEST_STATUS   = 3'd2,
    GEST_VOLUME   = 3'd3,
    GEST_BRIGHT   = 3'd4
  } gesture_t;

  typedef struct packed {
    logic [11:0] min_swipe;
    logic [15:0] long_press;
    logic [11:0] drift_lim;
    logic [15:0] cooldown;
    logic [6:0]  step;
    logic [3:0]  ratio_num;
    logic [3:0]  ratio_den;
  } cfg_t;

  // One decoded, clamped sample
  typedef struct packed {
    logic               touched;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [TIME_W-1:0]  now;
    logic               asleep;
  } sample_t;

  // Stroke bookkeeping
  typedef struct packed {
    logic               active;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] recent_x;
    logic [COORD_W-1:0] recent_y;
    logic [COORD_W-1:0] peak_drift;
    logic [TIME_W-1:0]  start_time;
    logic [TIME_W-1:0]  last_fire;
  } stroke_t;

  // Verdict on a release
  typedef struct packed {
    gesture_t           gesture;
    logic [DELTA_W-1:0] delta;
    logic               fire;
  } verdict_t;

  function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

/* hw/rtl/tgc_cfg_regs.sv */
// Configuration register file for the touch gesture classifier.
// Depends on tgc_pkg.
`timescale 1ns / 1ps

module tgc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tgc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tgc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output tgc_pkg::cfg_t                    cfg
);

  tgc_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_swipe  <= 12'd35;
      cfg_r.long_press <= 16'd800;
      cfg_r.drift_lim  <= 12'd20;
      cfg_r.cooldown   <= 16'd250;
      cfg_r.step       <= 7'd10;
      cfg_r.ratio_num  <= 4'd3;
      cfg_r.ratio_den  <= 4'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tgc_pkg::CFG_MIN_SWIPE:  cfg_r.min_swipe  <= cfg_wdata[11:0];
        tgc_pkg::CFG_LONG_PRESS: cfg_r.long_press <= cfg_wdata;
        tgc_pkg::CFG_DRIFT_LIM:  cfg_r.drift_lim  <= cfg_wdata[11:0];
        tgc_pkg::CFG_COOLDOWN:   cfg_r.cooldown   <= cfg_wdata;
        tgc_pkg::CFG_STEP:       cfg_r.step       <= cfg_wdata[6:0];
        tgc_pkg::CFG_RATIO_NUM:  cfg_r.ratio_num  <= cfg_wdata[3:0];
        tgc_pkg::CFG_RATIO_DEN:  cfg_r.ratio_den  <= cfg_wdata[3:0];
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* hw/rtl/tgc_sample_reg.sv */
// Input register: decodes the raw controller bytes, clamps to the display
// and holds one sample item. Depends on tgc_pkg.
`timescale 1ns / 1ps

module tgc_sample_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_status_byte,
  input  logic [7:0]           in_x_high_byte,
  input  logic [7:0]           in_x_low_byte,
  input  logic [7:0]           in_y_high_byte,
  input  logic [7:0]           in_y_low_byte,
  input  logic [31:0]          in_time_ms,
  input  logic                 in_asleep,
  input  logic                 take,
  output logic                 smp_valid,
  output tgc_pkg::sample_t     smp
);

  logic [tgc_pkg::COORD_W-1:0] raw_x, raw_y;
  tgc_pkg::sample_t            dec;
  tgc_pkg::sample_t            smp_r;
  logic                        vld_r, vld_nxt;

  always_comb begin
    raw_x       = {in_x_high_byte[3:0], in_x_low_byte};
    raw_y       = {in_y_high_byte[3:0], in_y_low_byte};
    dec.touched = (in_status_byte[3:0] != 4'd0);
    dec.x       = ({1'b0, raw_x} >= tgc_pkg::SCREEN_W_LIM)
                  ? tgc_pkg::COORD_W'(tgc_pkg::SCREEN_W_LIM - 13'd1) : raw_x;
    dec.y       = ({1'b0, raw_y} >= tgc_pkg::SCREEN_H_LIM)
                  ? tgc_pkg::COORD_W'(tgc_pkg::SCREEN_H_LIM - 13'd1) : raw_y;
    dec.now     = in_time_ms;
    dec.asleep  = in_asleep;
  end

  // Free when empty or when the held item moves on this cycle
  assign in_ready = !vld_r || take;

  always_comb begin
    vld_nxt = vld_r;
    if (take)
      vld_nxt = 1'b0;
    if (in_valid && in_ready)
      vld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      smp_r <= dec;
    end
  end

  assign smp_valid = vld_r;
  assign smp       = smp_r;

endmodule

/* hw/rtl/tgc_release_class.sv */
// Release classifier: cooldown, long press, tap, and axis-dominance swipe
// tests on a finished stroke. Pure logic. Depends on tgc_pkg.
`timescale 1ns / 1ps

module tgc_release_class (
  input  tgc_pkg::cfg_t       cfg,
  input  tgc_pkg::stroke_t    stroke,
  input  logic [31:0]         now,
  input  logic                asleep,
  output tgc_pkg::verdict_t   verdict
);

  logic [tgc_pkg::COORD_W-1:0] adx, ady;
  logic [31:0]                 since_fire, duration;
  logic [15:0]                 x_scaled, y_scaled, x_ref, y_ref;
  logic [7:0]                  step_pos, step_neg;
  logic                        in_cooldown, long_press, tap, horiz, vert;

  always_comb begin
    adx        = tgc_pkg::abs_diff(stroke.recent_x, stroke.start_x);
    ady        = tgc_pkg::abs_diff(stroke.recent_y, stroke.start_y);
    since_fire = now - stroke.last_fire;
    duration   = now - stroke.start_time;
    x_scaled   = 16'(adx) * 16'(cfg.ratio_den);
    y_ref      = 16'(ady) * 16'(cfg.ratio_num);
    y_scaled   = 16'(ady) * 16'(cfg.ratio_den);
    x_ref      = 16'(adx) * 16'(cfg.ratio_num);
    step_pos   = {1'b0, cfg.step};
    step_neg   = 8'd0 - step_pos;

    in_cooldown = since_fire < {16'd0, cfg.cooldown};
    long_press  = (duration >= {16'd0, cfg.long_press})
                  && (stroke.peak_drift < cfg.drift_lim);
    tap         = (adx < cfg.min_swipe) && (ady < cfg.min_swipe);
    horiz       = x_scaled >= y_ref;
    vert        = y_scaled >= x_ref;

    verdict.gesture = tgc_pkg::GEST_NONE;
    verdict.delta   = 8'd0;
    verdict.fire    = 1'b0;
    priority if (in_cooldown) begin
      verdict.fire = 1'b0;
    end else if (long_press) begin
      verdict.gesture = asleep ? tgc_pkg::GEST_NONE : tgc_pkg::GEST_STATUS;
      verdict.fire    = 1'b1;
    end else if (tap) begin
      verdict.fire = 1'b0;
    end else if (horiz) begin
      // rightward swipe dims, leftward brightens
      verdict.gesture = tgc_pkg::GEST_BRIGHT;
      verdict.delta   = (stroke.recent_x > stroke.start_x) ? step_neg : step_pos;
      verdict.fire    = 1'b1;
    end else if (vert) begin
      verdict.gesture = tgc_pkg::GEST_VOLUME;
      verdict.delta   = (stroke.recent_y > stroke.start_y) ? step_pos : step_neg;
      verdict.fire    = 1'b1;
    end else begin
      verdict.fire = 1'b0;  // diagonal: drop
    end
  end

endmodule

/* hw/rtl/touch_gesture_classifier_unit.sv */
// Top level of the touch gesture classifier: stroke state and result register.
// Depends on tgc_pkg, tgc_cfg_regs, tgc_sample_reg and tgc_release_class.
`timescale 1ns / 1ps

// Every sample item gives exactly one result item (gesture plus signed step).
// An item is registered on input, classified combinationally against the stroke
// state and lands in the result register, so a result is valid once its item
// has passed the sample register and the result register, and one item is
// accepted per clock while results are taken; the stroke state update sets that rate.
// A stalled result register holds the sample register, and input stalls only
// once both fill.
module touch_gesture_classifier_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_status_byte,
  input  logic [7:0]                        in_x_high_byte,
  input  logic [7:0]                        in_x_low_byte,
  input  logic [7:0]                        in_y_high_byte,
  input  logic [7:0]                        in_y_low_byte,
  input  logic [31:0]                       in_time_ms,
  input  logic                              in_asleep,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [2:0]                        out_gesture,
  output logic signed [7:0]                 out_step_delta,
  input  logic                              cfg_we,
  input  logic [tgc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tgc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  tgc_pkg::cfg_t      cfg;
  tgc_pkg::sample_t   smp;
  tgc_pkg::stroke_t   st_r, st_nxt;
  tgc_pkg::verdict_t  rel;
  tgc_pkg::gesture_t  gest_nxt, gest_r;
  logic [7:0]         delta_nxt, delta_r;
  logic               smp_valid, advance;
  logic               ovld_r, ovld_nxt;
  logic [tgc_pkg::COORD_W-1:0] ddx, ddy, drift;

  tgc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tgc_sample_reg u_smp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_status_byte (in_status_byte),
    .in_x_high_byte (in_x_high_byte),
    .in_x_low_byte  (in_x_low_byte),
    .in_y_high_byte (in_y_high_byte),
    .in_y_low_byte  (in_y_low_byte),
    .in_time_ms     (in_time_ms),
    .in_asleep      (in_asleep),
    .take           (advance),
    .smp_valid      (smp_valid),
    .smp            (smp)
  );

  tgc_release_class u_rel (
    .cfg     (cfg),
    .stroke  (st_r),
    .now     (smp.now),
    .asleep  (smp.asleep),
    .verdict (rel)
  );

  // Move the held sample into the result register when that has room
  assign advance = smp_valid && (!ovld_r || out_ready);

  always_comb begin
    ddx       = tgc_pkg::abs_diff(smp.x, st_r.start_x);
    ddy       = tgc_pkg::abs_diff(smp.y, st_r.start_y);
    drift     = (ddx > ddy) ? ddx : ddy;
    st_nxt    = st_r;
    gest_nxt  = tgc_pkg::GEST_NONE;
    delta_nxt = 8'd0;
    if (smp.touched) begin
      if (!st_r.active) begin
        st_nxt.active     = 1'b1;
        st_nxt.start_x    = smp.x;
        st_nxt.recent_x   = smp.x;
        st_nxt.start_y    = smp.y;
        st_nxt.recent_y   = smp.y;
        st_nxt.peak_drift = '0;
        st_nxt.start_time = smp.now;
        if (!smp.asleep)
          gest_nxt = tgc_pkg::GEST_ACTIVITY;
      end else begin
        if (drift > st_r.peak_drift)
          st_nxt.peak_drift = drift;
        st_nxt.recent_x = smp.x;
        st_nxt.recent_y = smp.y;
      end
    end else if (st_r.active) begin
      st_nxt.active = 1'b0;
      gest_nxt      = rel.gesture;
      delta_nxt     = rel.delta;
      if (rel.fire)
        st_nxt.last_fire = smp.now;
    end
  end

  always_comb begin
    ovld_nxt = ovld_r;
    if (out_ready)
      ovld_nxt = 1'b0;
    if (advance)
      ovld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= '0;
      ovld_r <= 1'b0;
    end else begin
      ovld_r <= ovld_nxt;
      if (advance)
        st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      gest_r  <= gest_nxt;
      delta_r <= delta_nxt;
    end
  end

  assign out_valid      = ovld_r;
  assign out_gesture    = gest_r;
  assign out_step_delta = delta_r;

  // Only adjustments carry a step
  a_delta_only_on_adjust: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_gesture != tgc_pkg::GEST_VOLUME
      && out_gesture != tgc_pkg::GEST_BRIGHT |-> out_step_delta == 8'd0)
    else $error("step delta set on a non-adjust gesture");

  // Stroke state moves only with an item
  a_stroke_holds: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(advance) |-> $stable(st_r))
    else $error("stroke state changed without an item");

  // An activity event always opens a stroke
  a_activity_opens: assert property (@(posedge clk) disable iff (!rst_n)
    advance && gest_nxt == tgc_pkg::GEST_ACTIVITY |=> st_r.active)
    else $error("activity event without an open stroke");

  // A release result closes the stroke
  a_release_closes: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !smp.touched |=> !st_r.active)
    else $error("stroke still open after a release");

endmodule
